// ----- sv/affine_warp_source_address_assert.svh -----
// Assertion macros used by the warp address generator top level.
`ifndef AFFINE_WARP_SOURCE_ADDRESS_ASSERT_SVH
`define AFFINE_WARP_SOURCE_ADDRESS_ASSERT_SVH
`ifndef SYNTHESIS
`define AWSA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("awsa assertion failed");
`define AWSA_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("awsa assertion failed");
`else
`define AWSA_ASSERT(label, clk, rst_n, prop)
`define AWSA_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- sv/awsa_pkg.sv -----
// Types, widths, register codes and sine table for the warp address generator.
`default_nettype none
package awsa_pkg;

    localparam int COL_W   = 10;
    localparam int ROW_W   = 9;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 10;
    localparam int TRIG_W  = 16;
    localparam int NSTG    = 8;

    // datapath widths per stage
    localparam int W1  = 14;   // centered + translated
    localparam int WP  = 20;   // scale product
    localparam int W2  = 15;   // scaled
    localparam int WT  = 21;   // shear sum
    localparam int W3  = 15;   // sheared
    localparam int WM  = 31;   // rotation product
    localparam int WR  = 32;   // rotation sum
    localparam int W4  = 16;   // rotated
    localparam int W5  = 17;   // uncentered

    // reciprocals: n/10 = (n*RCP10)>>20, n/50 = (n*RCP50)>>25, exact over our range
    localparam int RCP10_W  = 17;
    localparam int RCP10_SH = 20;
    localparam logic [RCP10_W-1:0] RCP10 = 17'd104858;
    localparam int RCP50_W  = 20;
    localparam int RCP50_SH = 25;
    localparam logic [RCP50_W-1:0] RCP50 = 20'd671089;

    localparam logic signed [WT-1:0] SHEAR_ONE = 21'sd50;
    localparam logic signed [WR-1:0] Q14_BIAS  = 32'sd16383;
    localparam int Q14_SH = 14;

    typedef enum logic [CFG_IW-1:0] {
        REG_SHIFT_X,
        REG_SHIFT_Y,
        REG_SCALE_X,
        REG_SCALE_Y,
        REG_SHEAR_X,
        REG_SHEAR_Y,
        REG_ANGLE
    } t_reg_idx;

    typedef struct packed {
        logic signed [9:0]        shift_x;
        logic signed [6:0]        shift_y;
        logic signed [5:0]        scale_x;
        logic signed [5:0]        scale_y;
        logic [4:0]               shear_x;
        logic [4:0]               shear_y;
        logic signed [TRIG_W-1:0] sin_q;
        logic signed [TRIG_W-1:0] cos_q;
    } t_warp_cfg;

    // round(16384*sin(k deg)), k = 0..90
    localparam logic [14:0] QSIN [0:90] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
        15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
        15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
        15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
        15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
        15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
        15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
        15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
        15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
        15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
        15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
        15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
        15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
        15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
        15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
        15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
        15'd16384
    };

    // sine in Q2.14 for d in 0..359, folded from the quarter wave
    function automatic logic signed [TRIG_W-1:0] sin_q14(input logic [8:0] d);
        logic [8:0]  k;
        logic        neg;
        logic [14:0] mag;
        if (d <= 9'd90) begin
            k   = d;
            neg = 1'b0;
        end else if (d <= 9'd180) begin
            k   = 9'd180 - d;
            neg = 1'b0;
        end else if (d <= 9'd270) begin
            k   = d - 9'd180;
            neg = 1'b1;
        end else begin
            k   = 9'd360 - d;
            neg = 1'b1;
        end
        mag = QSIN[k[6:0]];
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage
`default_nettype wire

// ----- sv/awsa_if.sv -----
// Request, response and configuration channel interfaces.
`default_nettype none
interface awsa_req_if;
    import awsa_pkg::*;
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] dest_col;
    logic [ROW_W-1:0] dest_row;
    modport source (output valid, dest_col, dest_row, input ready);
    modport sink   (input valid, dest_col, dest_row, output ready);
endinterface

interface awsa_rsp_if;
    import awsa_pkg::*;
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] src_col;
    logic [ROW_W-1:0] src_row;
    logic             in_range;
    modport source (output valid, src_col, src_row, in_range, input ready);
    modport sink   (input valid, src_col, src_row, in_range, output ready);
endinterface

interface awsa_cfg_if;
    import awsa_pkg::*;
    logic              valid;
    logic              ready;
    logic [CFG_IW-1:0] index;
    logic [CFG_DW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- sv/awsa_cfg.sv -----
// Configuration register file with registered sine and cosine of the angle.
`default_nettype none
module awsa_cfg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    awsa_cfg_if.sink             i_cfg,
    output awsa_pkg::t_warp_cfg  o_cfg
);
    import awsa_pkg::*;

    logic signed [9:0]        r_shift_x;
    logic signed [6:0]        r_shift_y;
    logic signed [5:0]        r_scale_x;
    logic signed [5:0]        r_scale_y;
    logic [4:0]               r_shear_x;
    logic [4:0]               r_shear_y;
    logic [8:0]               r_angle;
    logic signed [TRIG_W-1:0] r_sin;
    logic signed [TRIG_W-1:0] r_cos;
    logic [8:0]               n_ang;
    logic [8:0]               n_cos_ang;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_x <= '0;
            r_shift_y <= '0;
            r_scale_x <= 6'sd10;
            r_scale_y <= 6'sd10;
            r_shear_x <= '0;
            r_shear_y <= '0;
            r_angle   <= '0;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_SHIFT_X: begin
                    r_shift_x <= $signed(i_cfg.data[9:0]);
                end
                REG_SHIFT_Y: begin
                    r_shift_y <= $signed(i_cfg.data[6:0]);
                end
                REG_SCALE_X: begin
                    r_scale_x <= $signed(i_cfg.data[5:0]);
                end
                REG_SCALE_Y: begin
                    r_scale_y <= $signed(i_cfg.data[5:0]);
                end
                REG_SHEAR_X: begin
                    r_shear_x <= i_cfg.data[4:0];
                end
                REG_SHEAR_Y: begin
                    r_shear_y <= i_cfg.data[4:0];
                end
                REG_ANGLE: begin
                    r_angle <= i_cfg.data[8:0];
                end
                default: begin
                end
            endcase
        end
    end

    // angle mod 360, cosine as sine of angle + 90
    always_comb begin
        n_ang     = (r_angle >= 9'd360) ? r_angle - 9'd360 : r_angle;
        n_cos_ang = n_ang + 9'd90;
        if (n_cos_ang >= 9'd360) begin
            n_cos_ang = n_cos_ang - 9'd360;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sin <= '0;
            r_cos <= 16'sd16384;
        end else begin
            r_sin <= sin_q14(n_ang);
            r_cos <= sin_q14(n_cos_ang);
        end
    end

    always_comb begin
        o_cfg.shift_x = r_shift_x;
        o_cfg.shift_y = r_shift_y;
        o_cfg.scale_x = r_scale_x;
        o_cfg.scale_y = r_scale_y;
        o_cfg.shear_x = r_shear_x;
        o_cfg.shear_y = r_shear_y;
        o_cfg.sin_q   = r_sin;
        o_cfg.cos_q   = r_cos;
    end

endmodule
`default_nettype wire

// ----- sv/affine_warp_source_address.sv -----
// Top level: eight-stage pipeline from destination pixel to source pixel address.
// Throughput is one request per cycle; the whole pipeline holds while a
// response waits, so the rotation multipliers set the stage depth, not the rate.
// Reset clears all stage valids and loads register defaults; sine and cosine
// follow an angle write in the cycle after the angle register takes it.
`default_nettype none
`include "affine_warp_source_address_assert.svh"
module affine_warp_source_address #(
    parameter int IMG_WIDTH  = 640,
    parameter int IMG_HEIGHT = 480
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    awsa_req_if.sink  i_req,
    awsa_rsp_if.source o_rsp,
    awsa_cfg_if.sink  i_cfg
);
    import awsa_pkg::*;

    localparam logic signed [W1-1:0] HALF_W1 = W1'(IMG_WIDTH / 2);
    localparam logic signed [W1-1:0] HALF_H1 = W1'(IMG_HEIGHT / 2);
    localparam logic signed [W5-1:0] HALF_W5 = W5'(IMG_WIDTH / 2);
    localparam logic signed [W5-1:0] HALF_H5 = W5'(IMG_HEIGHT / 2);
    localparam logic signed [W5-1:0] IMG_W5  = W5'(IMG_WIDTH);
    localparam logic signed [W5-1:0] IMG_H5  = W5'(IMG_HEIGHT);

    function automatic logic signed [W2-1:0] div10(input logic signed [WP-1:0] p);
        logic [WP-1:0]         a;
        logic [WP+RCP10_W-1:0] prod;
        logic [W2-1:0]         q;
        a    = p[WP-1] ? WP'(-p) : WP'(p);
        prod = (WP+RCP10_W)'(a) * (WP+RCP10_W)'(RCP10);
        q    = prod[RCP10_SH +: W2];
        return p[WP-1] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [W3-1:0] div50(input logic signed [WT-1:0] t);
        logic [WT-1:0]         a;
        logic [WT+RCP50_W-1:0] prod;
        logic [W3-1:0]         q;
        a    = t[WT-1] ? WT'(-t) : WT'(t);
        prod = (WT+RCP50_W)'(a) * (WT+RCP50_W)'(RCP50);
        q    = prod[RCP50_SH +: W3];
        return t[WT-1] ? -$signed(q) : $signed(q);
    endfunction

    t_warp_cfg cfg;

    awsa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    logic [NSTG-1:0]       r_v;
    logic                  en;
    logic signed [W1-1:0]  r_x1, r_y1;
    logic signed [WP-1:0]  r_px, r_py;
    logic signed [W2-1:0]  r_x2, r_y2;
    logic signed [WT-1:0]  r_tx, r_ty;
    logic signed [W3-1:0]  r_x3, r_y3;
    logic signed [WM-1:0]  r_xc, r_ys, r_xs, r_yc;
    logic signed [W4-1:0]  r_x4, r_y4;
    logic [COL_W-1:0]      r_src_col;
    logic [ROW_W-1:0]      r_src_row;
    logic                  r_in_range;

    logic signed [W1-1:0]  n_x1, n_y1;
    logic signed [WT-1:0]  n_tx, n_ty;
    logic signed [WR-1:0]  n_sx, n_sy;
    logic signed [W4-1:0]  n_x4, n_y4;
    logic signed [W5-1:0]  n_x5, n_y5;
    logic                  n_ok;

    assign en          = !r_v[NSTG-1] || o_rsp.ready;
    assign i_req.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NSTG-2:0], i_req.valid};
        end
    end

    always_comb begin
        n_x1 = $signed({4'b0, i_req.dest_col}) - HALF_W1 + W1'(cfg.shift_x);
        n_y1 = $signed({5'b0, i_req.dest_row}) - HALF_H1 + W1'(cfg.shift_y);

        n_tx = WT'(r_x2) * SHEAR_ONE + WT'(r_y2) * $signed({16'b0, cfg.shear_x});
        n_ty = WT'(r_y2) * SHEAR_ONE + WT'(r_x2) * $signed({16'b0, cfg.shear_y});

        // rotate, then truncate toward zero on the Q14 shift
        n_sx = WR'(r_xc) - WR'(r_ys);
        n_sy = WR'(r_xs) + WR'(r_yc);
        n_x4 = W4'((n_sx + (n_sx[WR-1] ? Q14_BIAS : '0)) >>> Q14_SH);
        n_y4 = W4'((n_sy + (n_sy[WR-1] ? Q14_BIAS : '0)) >>> Q14_SH);

        n_x5 = W5'(r_x4) + HALF_W5;
        n_y5 = W5'(r_y4) + HALF_H5;
        n_ok = (n_x5 > 0) && (n_y5 > 0) && (n_x5 < IMG_W5) && (n_y5 < IMG_H5);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x1       <= n_x1;
            r_y1       <= n_y1;
            r_px       <= WP'(r_x1) * WP'(cfg.scale_x);
            r_py       <= WP'(r_y1) * WP'(cfg.scale_y);
            r_x2       <= div10(r_px);
            r_y2       <= div10(r_py);
            r_tx       <= n_tx;
            r_ty       <= n_ty;
            r_x3       <= div50(r_tx);
            r_y3       <= div50(r_ty);
            r_xc       <= WM'(r_x3) * WM'(cfg.cos_q);
            r_ys       <= WM'(r_y3) * WM'(cfg.sin_q);
            r_xs       <= WM'(r_x3) * WM'(cfg.sin_q);
            r_yc       <= WM'(r_y3) * WM'(cfg.cos_q);
            r_x4       <= n_x4;
            r_y4       <= n_y4;
            r_src_col  <= n_ok ? n_x5[COL_W-1:0] : '0;
            r_src_row  <= n_ok ? n_y5[ROW_W-1:0] : '0;
            r_in_range <= n_ok;
        end
    end

    assign o_rsp.valid    = r_v[NSTG-1];
    assign o_rsp.src_col  = r_src_col;
    assign o_rsp.src_row  = r_src_row;
    assign o_rsp.in_range = r_in_range;

    `AWSA_ASSERT(a_out_zero, i_clk, i_rst_n, o_rsp.valid && !o_rsp.in_range |-> o_rsp.src_col == '0 && o_rsp.src_row == '0)
    `AWSA_ASSERT(a_stall_hold, i_clk, i_rst_n, !en |=> $stable(r_v))
    `AWSA_ASSERT(a_mid_advance, i_clk, i_rst_n, en && r_v[3] |=> r_v[4])
    `AWSA_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_rsp.valid)

endmodule
`default_nettype wire
